FILE: rtl/core/binary_arithmetic_encoder_macros.svh
// Assertion macros shared by the binary arithmetic encoder RTL.
`ifndef BINARY_ARITHMETIC_ENCODER_MACROS_SVH
`define BINARY_ARITHMETIC_ENCODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BAE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bae: implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BAE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bae: next-cycle check failed");

`endif

FILE: rtl/core/bae_pkg.sv
// Shared constants and control/status types of the binary arithmetic encoder.
package bae_pkg;

  // Input command codes
  localparam logic CMD_ENCODE   = 1'b0;
  localparam logic CMD_FINALIZE = 1'b1;

  // Range reset values and shift fill
  localparam logic [31:0] RANGE_LOW_INIT  = 32'h0000_0000;
  localparam logic [31:0] RANGE_HIGH_INIT = 32'hffff_ffff;
  localparam logic [7:0]  HIGH_FILL       = 8'hff;
  localparam logic [7:0]  LOW_FILL        = 8'h00;

  // Most bytes emitted for one input beat, minus one
  localparam logic [1:0]  LAST_BYTE_IDX   = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture input beat and span
    logic mul;       // form span * probability
    logic upd;       // apply split to the range
    logic shift;     // shift range by one byte after an emitted byte
    logic rng_init;  // return range to reset values
  } bae_ctl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic agree_upd;  // top bytes agree after the split
    logic agree_nxt;  // top bytes agree after the next byte shift
    logic fin;        // current beat is a finalize
  } bae_sts_t;

endpackage

FILE: rtl/core/bae_if.sv
// Valid/ready channel interfaces for the encoder input and byte output.
interface bae_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic        bit_value;
  logic [15:0] prob_one;

  modport source (output valid, output cmd, output bit_value, output prob_one, input ready);
  modport sink   (input valid, input cmd, input bit_value, input prob_one, output ready);
endinterface

interface bae_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

FILE: rtl/core/bae_datapath.sv
// Range registers, split multiplier and byte shifter of the encoder.
module bae_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_cmd,
  input  logic              in_bit_value,
  input  logic [15:0]       in_prob_one,
  input  bae_pkg::bae_ctl_t ctl,
  output bae_pkg::bae_sts_t sts,
  output logic [7:0]        out_byte
);
  import bae_pkg::*;

  logic [31:0] low_r, low_nxt;
  logic [31:0] high_r, high_nxt;
  logic [31:0] span_r;
  logic [15:0] prob_r;
  logic        bit_r;
  logic        fin_r;
  logic [47:0] prod_r;

  logic [31:0] split;
  logic [31:0] upd_low;
  logic [31:0] upd_high;

  // Split point and the range it leaves
  assign split    = low_r + prod_r[47:16];
  assign upd_high = bit_r ? split : high_r;
  assign upd_low  = bit_r ? low_r : split + 32'd1;

  // Pick next range value
  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (ctl.rng_init) begin
      low_nxt  = RANGE_LOW_INIT;
      high_nxt = RANGE_HIGH_INIT;
    end else if (ctl.upd) begin
      low_nxt  = upd_low;
      high_nxt = upd_high;
    end else if (ctl.shift) begin
      low_nxt  = {low_r[23:0], LOW_FILL};
      high_nxt = {high_r[23:0], HIGH_FILL};
    end
  end

  // Hold range state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= RANGE_LOW_INIT;
      high_r <= RANGE_HIGH_INIT;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  // Capture beat; finalize codes a one at probability zero
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      span_r <= high_r - low_r;
      fin_r  <= (in_cmd == CMD_FINALIZE);
      bit_r  <= (in_cmd == CMD_FINALIZE) ? 1'b1 : in_bit_value;
      prob_r <= (in_cmd == CMD_FINALIZE) ? 16'd0 : in_prob_one;
    end
  end

  // Register the 32x16 product
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= {16'd0, span_r} * {32'd0, prob_r};
    end
  end

  assign sts.agree_upd = (upd_high[31:24] == upd_low[31:24]);
  assign sts.agree_nxt = (high_r[23:16] == low_r[23:16]);
  assign sts.fin       = fin_r;
  assign out_byte      = high_r[31:24];

endmodule

FILE: rtl/core/bae_ctrl.sv
// Sequencing state machine of the encoder: accept, multiply, update, emit.
module bae_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  input  bae_pkg::bae_sts_t sts,
  output bae_pkg::bae_ctl_t ctl
);
  import bae_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  // Last byte when four are out or the next top bytes differ
  assign out_last  = (cnt_r == LAST_BYTE_IDX) || !sts.agree_nxt;

  // Drive datapath commands
  always_comb begin
    ctl.load     = in_acc;
    ctl.mul      = (state_r == ST_MUL);
    ctl.upd      = (state_r == ST_UPD);
    ctl.shift    = out_acc;
    ctl.rng_init = sts.fin && (((state_r == ST_UPD) && !sts.agree_upd) ||
                               (out_acc && out_last));
  end

  // Advance state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cnt_nxt   = 2'd0;
        state_nxt = sts.agree_upd ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (out_last) state_nxt = ST_IDLE;
          else          cnt_nxt   = cnt_r + 2'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/binary_arithmetic_encoder.sv
// Top level of the carryless 32-bit binary arithmetic encoder.
// Usage:
//   in_if  takes one beat per symbol: cmd (0 encode, 1 finalize), bit_value and
//          prob_one, the probability of a one scaled by 65536.
//   out_if gives zero to four beats per input beat, each one compressed byte,
//          with last high on the final byte of that input beat.
// Timing: a beat accepted on in_if is captured, multiplied in the single 32x16
//   multiply stage and then applied to the range; its bytes then leave one by
//   one through the one-byte output port. Only one symbol is in flight;
//   in_if.ready is low from accept until the range update when no byte is
//   due, else until the last byte of that symbol is taken.
// Finalize emits four bytes and returns the range to [0, 0xffffffff].
// Reset (rst_n low, synchronous) sets the range to [0, 0xffffffff] and drops
//   any symbol in flight.
// Receiver stall: a byte holds on out_if, with last, until out_if.ready is high.
`include "binary_arithmetic_encoder_macros.svh"

module binary_arithmetic_encoder (
  input  logic        clk,
  input  logic        rst_n,
  bae_in_if.sink      in_if,
  bae_out_if.source   out_if
);
  import bae_pkg::*;

  bae_ctl_t ctl;
  bae_sts_t sts;

  bae_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_last  (out_if.last),
    .sts       (sts),
    .ctl       (ctl)
  );

  bae_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_cmd       (in_if.cmd),
    .in_bit_value (in_if.bit_value),
    .in_prob_one  (in_if.prob_one),
    .ctl          (ctl),
    .sts          (sts),
    .out_byte     (out_if.out_byte)
  );

  // Checks
  `BAE_ASSERT_IMP(a_no_overlap, out_if.valid, !in_if.ready)
  `BAE_ASSERT_NXT(a_acc_no_out, in_if.valid && in_if.ready, !out_if.valid && !in_if.ready)
  `BAE_ASSERT_IMP(a_fin_emits, in_if.valid && in_if.ready && (in_if.cmd == CMD_FINALIZE), ##3 out_if.valid)
  `BAE_ASSERT_IMP(a_single_cmd, ctl.upd, !ctl.shift && !ctl.load)

endmodule

FILE: bench/tb_binary_arithmetic_encoder.sv
// Self-checking testbench for the binary arithmetic encoder: symbol stream in, byte stream out.
`timescale 1ns / 1ps

module tb_binary_arithmetic_encoder;
  import bae_pkg::*;

  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_SYMBOLS  = 250;
  localparam int PRESSURE_AFTER  = 100;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 24;
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic        cmd;
    logic        bit_value;
    logic [15:0] prob_one;
  } symbol_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } coded_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  bae_in_if  in_ch ();
  bae_out_if out_ch ();

  binary_arithmetic_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Symbols waiting to be sent, and bytes the encoder still owes us
  symbol_t     symbol_q[$];
  coded_byte_t coded_q[$];

  // Shadow copy of the coding range
  logic [31:0] range_lo = RANGE_LOW_INIT;
  logic [31:0] range_hi = RANGE_HIGH_INIT;

  int n_total;
  int n_accepted = 0;
  int n_checked  = 0;
  int n_fail     = 0;
  int n_finalize = 0;
  int n_silent   = 0;
  int n_full     = 0;
  int cycle_count;

  // Work out the bytes one symbol produces and advance the shadow range
  function automatic void encode_symbol(symbol_t sym);
    logic [31:0] span;
    logic [47:0] prod;
    logic [31:0] split;
    logic [15:0] prob;
    logic        one;
    logic [7:0]  emitted[4];
    int          n;
    one  = (sym.cmd == CMD_FINALIZE) ? 1'b1 : sym.bit_value;
    prob = (sym.cmd == CMD_FINALIZE) ? 16'd0 : sym.prob_one;
    span = range_hi - range_lo;
    prod = 48'(span) * 48'(prob);
    split = range_lo + prod[47:16];
    if (one) begin
      range_hi = split;
    end else begin
      range_lo = split + 32'd1;
    end
    // emit while the top bytes agree, at most four per symbol
    n = 0;
    while (n < 4 && range_hi[31:24] == range_lo[31:24]) begin
      emitted[n] = range_hi[31:24];
      range_hi = {range_hi[23:0], HIGH_FILL};
      range_lo = {range_lo[23:0], LOW_FILL};
      n++;
    end
    for (int i = 0; i < n; i++) begin
      coded_q.insert(coded_q.size(), coded_byte_t'{value: emitted[i], last: (i == n - 1)});
    end
    if (sym.cmd == CMD_FINALIZE) begin
      range_lo = RANGE_LOW_INIT;
      range_hi = RANGE_HIGH_INIT;
      n_finalize++;
    end
    if (n == 0) n_silent++;
    if (n == 4) n_full++;
  endfunction

  // Probability mix: full range, both tails, exact extremes, the middle
  function automatic logic [15:0] pick_prob();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 16'($urandom_range(0, 65535));
    if (r < 60) return 16'($urandom_range(0, 255));
    if (r < 80) return 16'($urandom_range(16'hff00, 16'hffff));
    if (r < 90) return ($urandom_range(0, 1) != 0) ? 16'hffff : 16'h0000;
    return 16'($urandom_range(16'h7000, 16'h9000));
  endfunction

  // Idle lengths: mostly short, now and then long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Idling style rotates every 40 symbols: none, light, heavy
  function automatic int idle_mode();
    return (n_accepted / 40) % 3;
  endfunction

  function automatic void add_symbol(logic cmd, logic bv, logic [15:0] prob);
    symbol_q.insert(symbol_q.size(), symbol_t'{cmd: cmd, bit_value: bv, prob_one: prob});
  endfunction

  // Mostly runs of encodes closed by a finalize; bits follow their odds most of the time
  task automatic build_random();
    int          run_len;
    logic [15:0] prob;
    logic        bv;
    int          start;
    start = symbol_q.size();
    while (symbol_q.size() - start < RANDOM_SYMBOLS) begin
      run_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
      for (int i = 0; i < run_len; i++) begin
        prob = pick_prob();
        if ($urandom_range(0, 4) == 0) begin
          bv = 1'($urandom_range(0, 1));
        end else begin
          bv = ($urandom_range(0, 65535) < prob);
        end
        add_symbol(CMD_ENCODE, bv, prob);
      end
      add_symbol(CMD_FINALIZE, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
    end
  endtask

  // Sender: hold a beat until taken, then pause or move on
  int      send_gap;
  symbol_t next_sym;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.cmd       <= CMD_ENCODE;
      in_ch.bit_value <= 1'b0;
      in_ch.prob_one  <= 16'd0;
      send_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        encode_symbol('{cmd: in_ch.cmd, bit_value: in_ch.bit_value, prob_one: in_ch.prob_one});
        n_accepted++;
        if (idle_mode() != 0 && $urandom_range(0, 99) < 35) send_gap = pick_idle_len();
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (symbol_q.size() > 0) begin
          next_sym = symbol_q.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.cmd       <= next_sym.cmd;
          in_ch.bit_value <= next_sym.bit_value;
          in_ch.prob_one  <= next_sym.prob_one;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each byte beat, stall at random, and hold off once for a long stretch
  int          hold_left;
  bit          pressure_done = 1'b0;
  coded_byte_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (coded_q.size() == 0) begin
          $error("out_byte %02h arrived with no byte pending", out_ch.out_byte);
          n_fail++;
        end else begin
          want = coded_q.pop_front();
          n_checked++;
          if (out_ch.out_byte !== want.value) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.value, out_ch.out_byte);
            n_fail++;
          end
          if (out_ch.last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, out_ch.last);
            n_fail++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!pressure_done && n_accepted >= PRESSURE_AFTER) begin
        pressure_done = 1'b1;
        hold_left = PRESSURE_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (idle_mode() != 0 && $urandom_range(0, 99) < 20 * idle_mode()) begin
        hold_left = pick_idle_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;

    // Directed: collapse at probability zero, both extremes, the midpoint,
    // a split that emits nothing, finalize from fresh and busy ranges
    add_symbol(CMD_ENCODE,   1'b1, 16'h0000);
    add_symbol(CMD_ENCODE,   1'b0, 16'hffff);
    add_symbol(CMD_ENCODE,   1'b1, 16'hffff);
    add_symbol(CMD_ENCODE,   1'b0, 16'h0000);
    add_symbol(CMD_FINALIZE, 1'b0, 16'h0000);
    add_symbol(CMD_ENCODE,   1'b0, 16'h8000);
    add_symbol(CMD_ENCODE,   1'b1, 16'h8000);
    add_symbol(CMD_ENCODE,   1'b1, 16'h0001);
    add_symbol(CMD_ENCODE,   1'b0, 16'hfffe);
    add_symbol(CMD_ENCODE,   1'b1, 16'h0101);
    add_symbol(CMD_ENCODE,   1'b0, 16'hff00);
    add_symbol(CMD_ENCODE,   1'b0, 16'hffff);
    add_symbol(CMD_FINALIZE, 1'b1, 16'hffff);
    add_symbol(CMD_FINALIZE, 1'b1, 16'h5a5a);
    add_symbol(CMD_FINALIZE, 1'b0, 16'ha5a5);
    add_symbol(CMD_ENCODE,   1'b0, 16'h00ff);
    add_symbol(CMD_ENCODE,   1'b1, 16'hff00);
    add_symbol(CMD_ENCODE,   1'b1, 16'h0000);
    add_symbol(CMD_ENCODE,   1'b0, 16'h7fff);
    add_symbol(CMD_FINALIZE, 1'b0, 16'hffff);
    build_random();
    n_total = symbol_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent and every owed byte seen, then let the pipe settle
    while (n_accepted < n_total || coded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Encoded %0d symbols (%0d finalizes), checked %0d output bytes.",
             n_accepted, n_finalize, n_checked);
    $display("Symbols with no byte out: %0d, with four bytes out: %0d.", n_silent, n_full);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bae_pkg.sv
rtl/core/bae_if.sv
rtl/core/bae_datapath.sv
rtl/core/bae_ctrl.sv
rtl/core/binary_arithmetic_encoder.sv
bench/tb_binary_arithmetic_encoder.sv
